[src/pfde_pkg.sv]
package pfde_pkg;

	// Screen geometry
	localparam int SCREEN_WIDTH  = 96;
	localparam int SCREEN_HEIGHT = 65;
	localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;

	// Derived widths
	localparam int ADDR_W  = $clog2(STORE_BYTES);
	localparam int COL_W   = $clog2(SCREEN_WIDTH + 1);
	localparam int ROW_W   = $clog2(SCREEN_HEIGHT + 1);
	localparam int PAGE_W  = $clog2(PAGE_COUNT + 1);
	localparam int COORD_W = 11;

	// Stream payload widths
	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 8;

	// Fill values
	localparam logic [7:0] BYTE_ONES  = 8'hFF;
	localparam logic [7:0] BYTE_ZEROS = 8'h00;

	// Command codes
	typedef enum logic [2:0] {
		ACT_PIXEL       = 3'd0,
		ACT_FILL_RECT   = 3'd1,
		ACT_OUTLINE     = 3'd2,
		ACT_FILL_SCREEN = 3'd3,
		ACT_READ_PIXEL  = 3'd4,
		ACT_READ_BYTE   = 3'd5
	} action_t;

	// Engine states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_SETUP,
		ST_RD,
		ST_WR,
		ST_FILL,
		ST_RDWAIT,
		ST_DONE
	} state_t;

endpackage

[src/pfde_ram.sv]
module pfde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/page_framebuffer_draw_engine.sv]
// Monochrome frame store of SCREEN_WIDTH x SCREEN_HEIGHT pixels kept as pages of eight
// rows, one byte per column and page (bit y mod 8 of byte x + (y / 8) * SCREEN_WIDTH),
// with a small drawing engine in front. Each command on the input stream (set or clear
// a pixel, fill a rectangle, draw a rectangle outline, fill the screen, read a pixel,
// read a byte) yields exactly one result on the output stream; drawing commands return
// zero, off-screen reads return zero, off-screen drawing is clipped. After reset the
// store is swept to zero, one byte a cycle, so s_tready stays low until the sweep ends.
// The store sits in one RAM with a registered read, and every drawn byte is a read
// then a write; a screen fill writes the whole store, and an off-screen read, an
// empty outline and an unused action code go straight from decode to done. A result
// held on m_tready keeps the engine in its done state. A new command is taken while
// the previous result still waits on m_tready.
module page_framebuffer_draw_engine import pfde_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// pos_x[8:0], pos_y[17:9], rect_w[25:18], rect_h[33:26], ink[34], zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// action[2:0]
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// read_data[7:0]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam logic signed [COORD_W-1:0] WIDTH_S  = COORD_W'(SCREEN_WIDTH);
	localparam logic signed [COORD_W-1:0] HEIGHT_S = COORD_W'(SCREEN_HEIGHT);
	localparam logic signed [COORD_W-1:0] PAGES_S  = COORD_W'(PAGE_COUNT);
	localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(STORE_BYTES - 1);

	function automatic logic [COORD_W-1:0] clamp_coord(
		input logic signed [COORD_W-1:0] v,
		input logic signed [COORD_W-1:0] lim
	);
		logic [COORD_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > lim) begin
			r = lim;
		end else begin
			r = v;
		end
		return r;
	endfunction

	state_t state_q, state_d;

	// Command fields
	logic [2:0]        act_q;
	logic signed [8:0] x_q, y_q;
	logic [7:0]        w_q, h_q;
	logic              ink_q;

	// Rectangle walk
	logic [1:0]        pass_q;
	logic [COL_W-1:0]  col_q, col_lo_q, col_hi_q;
	logic [ROW_W-1:0]  row_lo_q, row_last_q;
	logic [PAGE_W-1:0] page_q;
	logic [ADDR_W-1:0] base_q, sweep_q;

	// Results
	logic [7:0] result_q, m_tdata_q;
	logic       m_tvalid_q;

	// Memory port
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_wdata, ram_rdata;

	// Pass geometry
	logic signed [COORD_W-1:0] xs, ys, rx, ry, rx_end, ry_end;
	logic [7:0]                rw, rh;
	logic [COL_W-1:0]          x0, x1;
	logic [ROW_W-1:0]          y0, y1, y_last;
	logic [PAGE_W-1:0]         page0, page_first, page_last, rd_page;
	logic [ADDR_W-1:0]         base0, draw_addr, rd_addr;
	logic                      rect_empty, col_end, page_end, last_pass, rd_ok, done_go;
	logic [2:0]                lo_bit, hi_bit;
	logic [7:0]                mask, wr_data;

	pfde_ram #(
		.WIDTH (8),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Pick the rectangle for this pass; an outline is four one-pixel-thick rectangles
	always_comb begin
		xs = {{(COORD_W - 9){x_q[8]}}, x_q};
		ys = {{(COORD_W - 9){y_q[8]}}, y_q};
		rx = xs;
		ry = ys;
		rw = w_q;
		rh = h_q;
		if (act_q == ACT_PIXEL) begin
			rw = 8'd1;
			rh = 8'd1;
		end else if (act_q == ACT_OUTLINE) begin
			case (pass_q)
				2'd0: begin
					rh = 8'd1;
				end
				2'd1: begin
					ry = ys + COORD_W'(h_q) - COORD_W'(1);
					rh = 8'd1;
				end
				2'd2: begin
					rw = 8'd1;
				end
				default: begin
					rx = xs + COORD_W'(w_q) - COORD_W'(1);
					rw = 8'd1;
				end
			endcase
		end
		rx_end = rx + COORD_W'(rw);
		ry_end = ry + COORD_W'(rh);
	end

	// Clip the pass rectangle to the screen
	always_comb begin
		x0         = COL_W'(clamp_coord(rx, WIDTH_S));
		x1         = COL_W'(clamp_coord(rx_end, WIDTH_S));
		y0         = ROW_W'(clamp_coord(ry, HEIGHT_S));
		y1         = ROW_W'(clamp_coord(ry_end, HEIGHT_S));
		y_last     = y1 - ROW_W'(1);
		rect_empty = (x0 >= x1) || (y0 >= y1);
		page0      = PAGE_W'(y0 >> 3);
		base0      = ADDR_W'(page0) * ADDR_W'(SCREEN_WIDTH);
	end

	// Byte walk: address, row mask within the page, modified byte
	always_comb begin
		draw_addr  = base_q + ADDR_W'(col_q);
		page_first = PAGE_W'(row_lo_q >> 3);
		page_last  = PAGE_W'(row_last_q >> 3);
		col_end    = (col_q + COL_W'(1)) == col_hi_q;
		page_end   = page_q == page_last;
		last_pass  = (act_q != ACT_OUTLINE) || (pass_q == 2'd3);
		lo_bit     = (page_q == page_first) ? row_lo_q[2:0] : 3'd0;
		hi_bit     = (page_q == page_last) ? row_last_q[2:0] : 3'd7;
		mask       = (BYTE_ONES << lo_bit) & (BYTE_ONES >> (3'd7 - hi_bit));
		wr_data    = ink_q ? (ram_rdata | mask) : (ram_rdata & ~mask);
	end

	// Read commands: range check and address
	always_comb begin
		if (act_q == ACT_READ_PIXEL) begin
			rd_ok = (xs >= 0) && (xs < WIDTH_S) && (ys >= 0) && (ys < HEIGHT_S);
		end else begin
			rd_ok = (xs >= 0) && (xs < WIDTH_S) && (ys >= 0) && (ys < PAGES_S);
		end
		rd_page = (act_q == ACT_READ_BYTE) ? PAGE_W'(y_q) : PAGE_W'(y_q >> 3);
		rd_addr = ADDR_W'(rd_page) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(x_q[COL_W-1:0]);
	end

	assign done_go = !m_tvalid_q || m_tready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sweep_q == SWEEP_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (act_q)
					ACT_PIXEL, ACT_FILL_RECT: begin
						state_d = ST_SETUP;
					end
					ACT_OUTLINE: begin
						state_d = (w_q == 8'd0 || h_q == 8'd0) ? ST_DONE : ST_SETUP;
					end
					ACT_FILL_SCREEN: begin
						state_d = ST_FILL;
					end
					ACT_READ_PIXEL, ACT_READ_BYTE: begin
						state_d = rd_ok ? ST_RDWAIT : ST_DONE;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_SETUP: begin
				if (!rect_empty) begin
					state_d = ST_RD;
				end else if (last_pass) begin
					state_d = ST_DONE;
				end
			end
			ST_RD: begin
				state_d = ST_WR;
			end
			ST_WR: begin
				if (!(col_end && page_end)) begin
					state_d = ST_RD;
				end else begin
					state_d = last_pass ? ST_DONE : ST_SETUP;
				end
			end
			ST_FILL: begin
				if (sweep_q == SWEEP_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_RDWAIT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (done_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs: handshake and memory port
	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = draw_addr;
		ram_wdata = wr_data;
		ram_raddr = draw_addr;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
				ram_wdata = BYTE_ZEROS;
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
				ram_wdata = ink_q ? BYTE_ONES : BYTE_ZEROS;
			end
			ST_DECODE: begin
				ram_raddr = rd_addr;
			end
			ST_WR: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			sweep_q    <= '0;
			pass_q     <= 2'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// Advance the sweep address during clear and screen fill
			if (state_q == ST_CLEAR || state_q == ST_FILL) begin
				sweep_q <= sweep_q + ADDR_W'(1);
			end else if (state_q == ST_DECODE) begin
				sweep_q <= '0;
			end

			// Step through the outline passes
			if (state_q == ST_DECODE) begin
				pass_q <= 2'd0;
			end else if (!last_pass && ((state_q == ST_SETUP && rect_empty) ||
					(state_q == ST_WR && col_end && page_end))) begin
				pass_q <= pass_q + 2'd1;
			end

			// Hold the result until the output transaction completes
			if (state_q == ST_DONE && done_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			act_q <= s_tuser;
			x_q   <= s_tdata[8:0];
			y_q   <= s_tdata[17:9];
			w_q   <= s_tdata[25:18];
			h_q   <= s_tdata[33:26];
			ink_q <= s_tdata[34];
		end

		if (state_q == ST_DECODE) begin
			result_q <= BYTE_ZEROS;
		end

		// Load the clipped bounds for a pass
		if (state_q == ST_SETUP && !rect_empty) begin
			col_lo_q   <= x0;
			col_hi_q   <= x1;
			row_lo_q   <= y0;
			row_last_q <= y_last;
			col_q      <= x0;
			page_q     <= page0;
			base_q     <= base0;
		end

		// Advance along the columns, then down to the next page
		if (state_q == ST_WR) begin
			if (!col_end) begin
				col_q <= col_q + COL_W'(1);
			end else if (!page_end) begin
				col_q  <= col_lo_q;
				page_q <= page_q + PAGE_W'(1);
				base_q <= base_q + ADDR_W'(SCREEN_WIDTH);
			end
		end

		// Capture read data
		if (state_q == ST_RDWAIT) begin
			if (act_q == ACT_READ_PIXEL) begin
				result_q <= {7'd0, ram_rdata[y_q[2:0]]};
			end else begin
				result_q <= ram_rdata;
			end
		end

		if (state_q == ST_DONE && done_go) begin
			m_tdata_q <= result_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[src/pfde_checker.sv]
module pfde_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	logic [1:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// Count commands accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (!in_acc && out_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");

	// Never offer a result without a pending command
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pend_q != 2'd0))
		else $error("result without command");

	// At most one command in work plus one result waiting
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("too many commands pending");

	// Take a new command only when no command is still in work
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (pend_q <= 2'd1))
		else $error("command accepted while engine busy");

endmodule

bind page_framebuffer_draw_engine pfde_checker u_pfde_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import pfde_pkg::*;

	// Spare command codes the block must ignore
	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;

	localparam int NUM_DIRECTED = 24;
	localparam int RANDOM_CMDS  = 1276;
	localparam int CALM_TAIL    = 200;
	localparam int HOLD_AT      = 300;
	localparam int DRAIN_AT     = 650;
	localparam int LONG_HOLD    = 3000;
	localparam int TAIL_CYCLES  = 64;
	localparam int CYCLE_LIMIT  = 8000000;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [2:0] act;
		int         px;
		int         py;
		int         rw;
		int         rh;
		logic       ink;
		logic       known;
		logic [7:0] known_val;
	} cmd_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [IN_USER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	page_framebuffer_draw_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Shadow copy of the frame store and the read data still owed by the block
	logic [7:0] shadow_frame [STORE_BYTES];
	logic [7:0] read_data_due [$];
	logic [7:0] due_byte;
	int         mismatches;
	int         cycle_count;
	bit         quiet;
	bit         hold_req;

	// Edge cases first; a typed value replaces the prediction where it is obvious
	cmd_row_t directed_rows [NUM_DIRECTED] = '{
		'{ACT_READ_BYTE,   0,    0,    0,   0,   1'b0, 1'b1, BYTE_ZEROS},
		'{ACT_READ_PIXEL,  95,   64,   0,   0,   1'b0, 1'b1, BYTE_ZEROS},
		'{ACT_PIXEL,       0,    0,    0,   0,   1'b1, 1'b1, BYTE_ZEROS},
		'{ACT_READ_PIXEL,  0,    0,    0,   0,   1'b0, 1'b1, 8'h01},
		'{ACT_PIXEL,       95,   64,   0,   0,   1'b1, 1'b1, BYTE_ZEROS},
		'{ACT_READ_BYTE,   95,   8,    0,   0,   1'b0, 1'b0, BYTE_ZEROS},
		'{ACT_PIXEL,       -256, -256, 0,   0,   1'b1, 1'b1, BYTE_ZEROS},
		'{ACT_READ_PIXEL,  -1,   0,    0,   0,   1'b0, 1'b1, BYTE_ZEROS},
		'{ACT_READ_PIXEL,  96,   0,    0,   0,   1'b0, 1'b1, BYTE_ZEROS},
		'{ACT_READ_BYTE,   0,    9,    0,   0,   1'b0, 1'b1, BYTE_ZEROS},
		'{ACT_READ_BYTE,   -256, 0,    0,   0,   1'b0, 1'b1, BYTE_ZEROS},
		'{ACT_FILL_RECT,   -5,   -5,   255, 255, 1'b1, 1'b1, BYTE_ZEROS},
		'{ACT_READ_BYTE,   50,   8,    0,   0,   1'b0, 1'b0, BYTE_ZEROS},
		'{ACT_FILL_RECT,   10,   10,   0,   20,  1'b0, 1'b1, BYTE_ZEROS},
		'{ACT_FILL_RECT,   10,   10,   20,  0,   1'b0, 1'b1, BYTE_ZEROS},
		'{ACT_OUTLINE,     10,   10,   1,   1,   1'b0, 1'b1, BYTE_ZEROS},
		'{ACT_OUTLINE,     20,   3,    1,   30,  1'b0, 1'b1, BYTE_ZEROS},
		'{ACT_OUTLINE,     -10,  -10,  200, 100, 1'b0, 1'b1, BYTE_ZEROS},
		'{ACT_READ_PIXEL,  10,   10,   0,   0,   1'b0, 1'b0, BYTE_ZEROS},
		'{ACT_FILL_SCREEN, 0,    0,    0,   0,   1'b1, 1'b1, BYTE_ZEROS},
		'{ACT_READ_BYTE,   40,   8,    0,   0,   1'b0, 1'b1, BYTE_ONES},
		'{ACT_SPARE_6,     1,    1,    3,   3,   1'b0, 1'b1, BYTE_ZEROS},
		'{ACT_FILL_SCREEN, 0,    0,    0,   0,   1'b0, 1'b1, BYTE_ZEROS},
		'{ACT_SPARE_7,     255,  255,  255, 255, 1'b1, 1'b1, BYTE_ZEROS}
	};

	// Set or clear one pixel, drop it when off screen
	function automatic void plot_dot(int x, int y, logic ink);
		int idx;
		if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT)
			return;
		idx = x + (y / 8) * SCREEN_WIDTH;
		shadow_frame[idx][y % 8] = ink;
	endfunction

	function automatic void paint_box(int x, int y, int w, int h, logic ink);
		int x0, x1, y0, y1;
		x0 = (x < 0) ? 0 : x;
		y0 = (y < 0) ? 0 : y;
		x1 = (x + w > SCREEN_WIDTH) ? SCREEN_WIDTH : x + w;
		y1 = (y + h > SCREEN_HEIGHT) ? SCREEN_HEIGHT : y + h;
		for (int i = y0; i < y1; i++)
			for (int j = x0; j < x1; j++)
				plot_dot(j, i, ink);
	endfunction

	// Walk the clipped spans but plot the unclipped edge lines
	function automatic void trace_box(int x, int y, int w, int h, logic ink);
		int x0, x1, y0, y1;
		x0 = (x < 0) ? 0 : x;
		y0 = (y < 0) ? 0 : y;
		x1 = (x + w > SCREEN_WIDTH) ? SCREEN_WIDTH : x + w;
		y1 = (y + h > SCREEN_HEIGHT) ? SCREEN_HEIGHT : y + h;
		if (w <= 0 || h <= 0)
			return;
		for (int i = x0; i < x1; i++) begin
			plot_dot(i, y, ink);
			plot_dot(i, y + h - 1, ink);
		end
		for (int i = y0; i < y1; i++) begin
			plot_dot(x, i, ink);
			plot_dot(x + w - 1, i, ink);
		end
	endfunction

	// Apply one command to the shadow store and return its read data
	function automatic logic [7:0] apply_command(logic [2:0] act, int x, int y, int w, int h,
		logic ink);
		logic [7:0] data;
		data = BYTE_ZEROS;
		case (act)
			ACT_PIXEL:       plot_dot(x, y, ink);
			ACT_FILL_RECT:   paint_box(x, y, w, h, ink);
			ACT_OUTLINE:     trace_box(x, y, w, h, ink);
			ACT_FILL_SCREEN: begin
				foreach (shadow_frame[i])
					shadow_frame[i] = ink ? BYTE_ONES : BYTE_ZEROS;
			end
			ACT_READ_PIXEL: begin
				if (x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT)
					data = {7'b0, shadow_frame[x + (y / 8) * SCREEN_WIDTH][y % 8]};
			end
			ACT_READ_BYTE: begin
				if (x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < PAGE_COUNT)
					data = shadow_frame[x + y * SCREEN_WIDTH];
			end
			default: ;
		endcase
		return data;
	endfunction

	// Offer one command, wait for its transaction, then record what it should return
	task automatic issue(input logic [2:0] act, input int px, input int py, input int rw,
		input int rh, input logic ink, input logic known, input logic [7:0] known_val);
		logic [8:0] fx, fy;
		logic [7:0] fw, fh;
		logic [7:0] predicted;
		int gap;
		fx = px[8:0];
		fy = py[8:0];
		fw = rw[7:0];
		fh = rh[7:0];
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 12);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, ink, fh, fw, fy, fx};
		s_tuser  <= act;
		do @(posedge clk); while (s_tready !== 1'b1);
		predicted = apply_command(act, int'($signed(fx)), int'($signed(fy)), int'(fw),
			int'(fh), ink);
		read_data_due.push_back(known ? known_val : predicted);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Abort a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	// Drive m_tready: random stalls, one long hold-off, steady near the end
	initial begin
		m_tready <= 1'b0;
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	// Compare each result transaction with the oldest pending read data
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (read_data_due.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("cycle %0d: unexpected result, read_data %02h", cycle_count,
						m_tdata);
				mismatches++;
			end else begin
				due_byte = read_data_due.pop_front();
				if (m_tdata !== due_byte) begin
					if (mismatches < MAX_REPORTS)
						$display("cycle %0d: read_data expected %02h, got %02h", cycle_count,
							due_byte, m_tdata);
					mismatches++;
				end
			end
		end
	end

	// Reset, directed table, random commands, drain
	initial begin
		int act_pick;
		int px, py, rw, rh;
		logic [2:0] act;
		logic ink;
		mismatches = 0;
		quiet      = 1'b0;
		hold_req   = 1'b0;
		foreach (shadow_frame[i])
			shadow_frame[i] = BYTE_ZEROS;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_DIRECTED; i++)
			issue(directed_rows[i].act, directed_rows[i].px, directed_rows[i].py,
				directed_rows[i].rw, directed_rows[i].rh, directed_rows[i].ink,
				directed_rows[i].known, directed_rows[i].known_val);

		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (n == RANDOM_CMDS - CALM_TAIL)
				quiet = 1'b1;
			if (n == HOLD_AT)
				hold_req = 1'b1;
			// Hold off until every pending result has come back
			if (n == DRAIN_AT) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (read_data_due.size() != 0);
			end

			act_pick = $urandom_range(0, 99);
			if (act_pick < 25)
				act = ACT_PIXEL;
			else if (act_pick < 37)
				act = ACT_FILL_RECT;
			else if (act_pick < 49)
				act = ACT_OUTLINE;
			else if (act_pick < 50)
				act = ACT_FILL_SCREEN;
			else if (act_pick < 75)
				act = ACT_READ_PIXEL;
			else if (act_pick < 97)
				act = ACT_READ_BYTE;
			else
				act = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;

			// Mostly on or near the screen, sometimes anywhere in the field range
			if ($urandom_range(0, 9) == 0) begin
				px = $urandom_range(0, 511);
				py = $urandom_range(0, 511);
			end else begin
				px = int'($urandom_range(0, 111)) - 8;
				if (act == ACT_READ_BYTE)
					py = int'($urandom_range(0, 10)) - 1;
				else
					py = int'($urandom_range(0, 80)) - 8;
			end
			rw  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20);
			rh  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20);
			ink = $urandom_range(0, 1);
			issue(act, px, py, rw, rh, ink, 1'b0, BYTE_ZEROS);
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (read_data_due.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
